// File: hw/rtl/nsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types, codes and defaults for the null symbol detector.
// ----------------------------------------------------------------------------
package nsd_pkg;

  localparam int DEF_WINDOW      = 50;
  localparam int DEF_MAG_BITS    = 16;
  localparam int DEF_LEVEL_SHIFT = 17;

  localparam int LEVEL_OUT_W = 16;
  localparam int CNT_W       = 18;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int ATT_W       = 3;

  localparam logic [15:0] WARMUP_RST  = 16'd39321;
  localparam logic [17:0] DIP_TO_RST  = 18'd196608;
  localparam logic [11:0] NULL_LEN_RST = 12'd2656;
  localparam logic [ATT_W-1:0] NOSIG_ATTEMPTS = 3'd5;

  typedef enum logic [2:0] {
    PH_WARMUP = 3'd0,
    PH_FILL   = 3'd1,
    PH_DIP    = 3'd2,
    PH_END    = 3'd3,
    PH_HELD   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DIP     = 3'd1,
    EV_END     = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_NOSIG   = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARMUP      = 2'd0,
    CFG_DIP_TIMEOUT = 2'd1,
    CFG_NULL_LENGTH = 2'd2,
    CFG_SCAN_ENABLE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    event_t                 event_res;
    phase_t                 phase_code;
    logic [LEVEL_OUT_W-1:0] level_out;
  } nsd_result_t;

endpackage
`default_nettype wire

// File: hw/rtl/nsd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_in_if
// Sample channel: one magnitude and the lost-sync flag per beat.
// ----------------------------------------------------------------------------
interface nsd_in_if import nsd_pkg::*; #(
  parameter int MAG_BITS = DEF_MAG_BITS
);
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic                lost_sync;

  modport source (output valid, output magnitude, output lost_sync, input ready);
  modport sink   (input valid, input magnitude, input lost_sync, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nsd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_out_if
// Result channel: event, phase and level per beat.
// ----------------------------------------------------------------------------
interface nsd_out_if import nsd_pkg::*;;
  logic                   valid;
  logic                   ready;
  event_t                 event_res;
  phase_t                 phase_code;
  logic [LEVEL_OUT_W-1:0] level_out;

  modport source (output valid, output event_res, output phase_code, output level_out,
                  input ready);
  modport sink   (input valid, input event_res, input phase_code, input level_out,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nsd_window_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_window_mem
// Sample window store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nsd_window_mem import nsd_pkg::*; #(
  parameter int DEPTH = DEF_WINDOW,
  parameter int WIDTH = DEF_MAG_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/nsd_out_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_out_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module nsd_out_skid import nsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire nsd_result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  wire logic        out_ready,
  output nsd_result_t      out_data
);

  nsd_result_t skid_data;
  logic        skid_valid;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/null_symbol_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// null_symbol_detector
// Finds the null symbol of a frame from one envelope magnitude per beat.
// ----------------------------------------------------------------------------
// One sample is accepted every cycle unless the two-entry output buffer that
// registers results is full, so a stalled sink holds off input only then.
// All per-sample state is updated in the cycle of acceptance. The sample
// window lives in a WINDOW-entry memory; the entry a sample replaces is read
// one accepted beat ahead, at the pointer the previous beat leaves, so the
// read data is waiting when the sample arrives. It was written WINDOW beats
// earlier; read and write meet only on a timeout at entry zero. Configuration
// must be written only while no beat is in flight; the block does not check.
module null_symbol_detector import nsd_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int LEVEL_SHIFT = DEF_LEVEL_SHIFT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  nsd_in_if.sink                     sample_in,
  nsd_out_if.source                  result_out
);

  localparam int MAG_BITS = DEF_MAG_BITS;
  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = MAG_BITS + AW;
  localparam int LW    = MAG_BITS + LEVEL_SHIFT;
  localparam int CMP_W = MAG_BITS + LEVEL_SHIFT + AW + 3;
  localparam logic [CMP_W-1:0] DIP_MUL   = CMP_W'(WINDOW);
  localparam logic [CMP_W-1:0] END_MUL   = CMP_W'(3 * WINDOW);
  localparam logic [AW-1:0]    WP_LAST   = AW'(WINDOW - 1);
  localparam logic [CNT_W-1:0] WIN_COUNT = CNT_W'(WINDOW);

  // configuration
  logic [15:0] warmup_count;
  logic [17:0] dip_timeout;
  logic [11:0] null_length;
  logic        scan_enable;

  // state
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [AW-1:0]     wp, wp_next;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [LW-1:0]     level, level_next;
  logic [ATT_W-1:0]  att, att_next;

  logic              accept;
  logic              can_push;
  event_t            ev;
  logic [MAG_BITS-1:0] rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;

  logic              warm_go;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  fill_cnt;
  logic [AW-1:0]     fill_wp;
  logic [SUM_W-1:0]  fill_sum, slide_sum, test_sum;
  logic [AW-1:0]     slide_wp;
  logic [CMP_W-1:0]  dip_rhs, end_rhs;
  logic              dip_ok, end_ok;
  logic [ATT_W-1:0]  att_inc;
  nsd_result_t       res;
  nsd_result_t       res_q;

  assign accept = sample_in.valid && sample_in.ready;
  assign sample_in.ready = can_push;

  always_comb begin
    level_next = level - (level >> LEVEL_SHIFT) + LW'(sample_in.magnitude);

    warm_go  = (phase == PH_WARMUP) && (cnt < CNT_W'(warmup_count));
    cnt_inc  = cnt + 1'b1;
    fill_cnt = (phase == PH_WARMUP) ? '0 : cnt;
    fill_wp  = (phase == PH_WARMUP) ? '0 : wp;
    fill_sum = ((phase == PH_WARMUP) ? '0 : sum) + SUM_W'(sample_in.magnitude);
    slide_sum = sum + SUM_W'(sample_in.magnitude) - SUM_W'(rd_data);
    slide_wp  = (wp == WP_LAST) ? '0 : wp + 1'b1;
    test_sum  = (phase == PH_DIP || phase == PH_END) ? slide_sum : fill_sum;

    dip_rhs = CMP_W'(level_next) * DIP_MUL;
    end_rhs = CMP_W'(level_next) * END_MUL;
    dip_ok  = (CMP_W'(test_sum) << (LEVEL_SHIFT + 1)) <= dip_rhs;
    end_ok  = (CMP_W'(test_sum) << (LEVEL_SHIFT + 2)) >= end_rhs;
    att_inc = att + 1'b1;

    phase_next = phase;
    cnt_next   = cnt;
    wp_next    = wp;
    sum_next   = sum;
    att_next   = att;
    ev         = EV_NONE;
    mem_we     = 1'b0;
    mem_waddr  = wp;

    if (warm_go) begin
      cnt_next = cnt_inc;
      if (cnt_inc >= CNT_W'(warmup_count)) begin
        phase_next = PH_FILL;
        cnt_next   = '0;
        wp_next    = '0;
        sum_next   = '0;
      end
    end else begin
      unique case (phase)
        PH_WARMUP, PH_FILL: begin
          mem_we     = 1'b1;
          mem_waddr  = fill_wp;
          sum_next   = fill_sum;
          wp_next    = (fill_wp == WP_LAST) ? '0 : fill_wp + 1'b1;
          cnt_next   = fill_cnt + 1'b1;
          phase_next = PH_FILL;
          if (fill_cnt + 1'b1 >= WIN_COUNT) begin
            wp_next    = '0;
            cnt_next   = '0;
            phase_next = PH_DIP;
            if (dip_ok) begin
              ev         = EV_DIP;
              phase_next = PH_END;
              if (end_ok) begin
                ev         = EV_END;
                phase_next = PH_HELD;
              end
            end
          end
        end
        PH_DIP: begin
          mem_we   = 1'b1;
          sum_next = slide_sum;
          wp_next  = slide_wp;
          if (cnt >= dip_timeout) begin
            ev = EV_TIMEOUT;
            if (scan_enable) begin
              att_next = att_inc;
              if (att_inc >= NOSIG_ATTEMPTS) begin
                ev       = EV_NOSIG;
                att_next = '0;
              end
            end
            phase_next = PH_FILL;
            cnt_next   = '0;
            wp_next    = '0;
            sum_next   = '0;
          end else begin
            cnt_next = cnt_inc;
            if (dip_ok) begin
              ev         = EV_DIP;
              phase_next = PH_END;
              cnt_next   = '0;
              if (end_ok) begin
                ev         = EV_END;
                phase_next = PH_HELD;
              end
            end
          end
        end
        PH_END: begin
          mem_we   = 1'b1;
          sum_next = slide_sum;
          wp_next  = slide_wp;
          if (cnt >= CNT_W'(null_length) + WIN_COUNT) begin
            ev         = EV_TIMEOUT;
            phase_next = PH_FILL;
            cnt_next   = '0;
            wp_next    = '0;
            sum_next   = '0;
          end else begin
            cnt_next = cnt_inc;
            if (end_ok) begin
              ev         = EV_END;
              phase_next = PH_HELD;
              cnt_next   = '0;
            end
          end
        end
        PH_HELD: begin
          if (sample_in.lost_sync) begin
            phase_next = PH_FILL;
            cnt_next   = '0;
            wp_next    = '0;
            sum_next   = '0;
          end
        end
        default: begin
          phase_next = PH_FILL;
          cnt_next   = '0;
          wp_next    = '0;
          sum_next   = '0;
        end
      endcase
    end

    res.event_res  = ev;
    res.phase_code = phase_next;
    res.level_out  = LEVEL_OUT_W'(level_next[LW-1:LEVEL_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count <= WARMUP_RST;
      dip_timeout  <= DIP_TO_RST;
      null_length  <= NULL_LEN_RST;
      scan_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WARMUP:      warmup_count <= cfg_data[15:0];
        CFG_DIP_TIMEOUT: dip_timeout  <= cfg_data[17:0];
        CFG_NULL_LENGTH: null_length  <= cfg_data[11:0];
        CFG_SCAN_ENABLE: scan_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WARMUP;
      cnt   <= '0;
      wp    <= '0;
      sum   <= '0;
      level <= '0;
      att   <= '0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        cnt   <= cnt_next;
        wp    <= wp_next;
        sum   <= sum_next;
        level <= level_next;
      end
      if (cfg_we && cfg_idx_t'(cfg_index) == CFG_SCAN_ENABLE) begin
        att <= '0;
      end else if (accept) begin
        att <= att_next;
      end
    end
  end

  nsd_window_mem #(
    .DEPTH (WINDOW),
    .WIDTH (MAG_BITS)
  ) u_window (
    .clk   (clk),
    .we    (accept && mem_we),
    .waddr (mem_waddr),
    .wdata (sample_in.magnitude),
    .re    (accept),
    .raddr (wp_next),
    .rdata (rd_data)
  );

  nsd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (res_q)
  );

  assign result_out.event_res  = res_q.event_res;
  assign result_out.phase_code = res_q.phase_code;
  assign result_out.level_out  = res_q.level_out;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_out.valid)
    else $error("accepted beat produced no result");

  a_fill_pointer: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_FILL) |-> (wp == cnt[AW-1:0]))
    else $error("write pointer out of step with fill count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> result_out.valid)
    else $error("input stalled with no result waiting");
`endif

endmodule
`default_nettype wire

// File: sim/tb_null_symbol_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_null_symbol_detector
// Self-checking bench for the null symbol detector. Directed beats cover the
// warm-up, fill, held and timeout corners; random frames (signal, dip, signal,
// release) with noise bursts follow under four handshake idle mixes, with
// register changes between phases. An untimed model of the detector predicts
// each result beat, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_null_symbol_detector import nsd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_BEATS    = 40;

  typedef struct {
    logic [DEF_MAG_BITS-1:0] mag;
    logic                    lost;
  } sample_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nsd_in_if  smp_if ();
  nsd_out_if res_if ();

  null_symbol_detector dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (smp_if),
    .result_out (res_if)
  );

  // detector model state
  logic [15:0]             warm_cnt;
  logic [17:0]             dip_limit;
  logic [11:0]             null_len;
  logic                    scan_on;
  logic [DEF_MAG_BITS-1:0] win_mem [DEF_WINDOW];
  logic [63:0]             win_sum;
  logic [63:0]             lvl_acc;
  phase_t                  det_phase;
  int unsigned             det_count;
  int unsigned             wr_ptr;
  logic [ATT_W-1:0]        timeout_tally;

  sample_t     sample_queue[$];
  nsd_result_t expected_reports[$];
  logic [63:0] gen_level;
  int unsigned queued_beats;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  sample_t     nxt;
  nsd_result_t exp_r;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void reset_model();
    warm_cnt      = WARMUP_RST;
    dip_limit     = DIP_TO_RST;
    null_len      = NULL_LEN_RST;
    scan_on       = 1'b0;
    win_sum       = '0;
    lvl_acc       = '0;
    det_phase     = PH_WARMUP;
    det_count     = 0;
    wr_ptr        = 0;
    timeout_tally = '0;
    foreach (win_mem[i]) win_mem[i] = '0;
  endfunction

  function automatic void apply_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WARMUP: warm_cnt = d[15:0];
      CFG_DIP_TIMEOUT: dip_limit = d[17:0];
      CFG_NULL_LENGTH: null_len = d[11:0];
      CFG_SCAN_ENABLE: begin
        scan_on       = d[0];
        timeout_tally = '0;
      end
    endcase
  endfunction

  function automatic void restart_fill();
    det_phase = PH_FILL;
    det_count = 0;
    wr_ptr    = 0;
    win_sum   = '0;
  endfunction

  function automatic void slide_window(logic [DEF_MAG_BITS-1:0] mag);
    int unsigned slot;
    slot            = wr_ptr % DEF_WINDOW;
    win_sum         = win_sum + mag - win_mem[slot];
    win_mem[slot]   = mag;
    wr_ptr          = (slot + 1 == DEF_WINDOW) ? 0 : slot + 1;
  endfunction

  // apply the dip test, then the end test, on the current window
  function automatic event_t settle_search();
    event_t ev;
    ev = EV_NONE;
    if (det_phase == PH_DIP &&
        ((win_sum * 2) << DEF_LEVEL_SHIFT) <= DEF_WINDOW * lvl_acc) begin
      ev        = EV_DIP;
      det_phase = PH_END;
      det_count = 0;
    end
    if (det_phase == PH_END &&
        ((win_sum * 4) << DEF_LEVEL_SHIFT) >= 3 * DEF_WINDOW * lvl_acc) begin
      ev        = EV_END;
      det_phase = PH_HELD;
      det_count = 0;
    end
    return ev;
  endfunction

  function automatic nsd_result_t detect_step(logic [DEF_MAG_BITS-1:0] mag, logic lost);
    event_t      ev;
    bit          consumed;
    nsd_result_t r;
    ev       = EV_NONE;
    consumed = 0;
    lvl_acc  = lvl_acc - (lvl_acc >> DEF_LEVEL_SHIFT) + 64'(mag);
    if (det_phase == PH_WARMUP) begin
      if (det_count < warm_cnt) begin
        det_count++;
        consumed = 1;
        if (det_count >= warm_cnt) restart_fill();
      end else begin
        restart_fill();
      end
    end
    if (!consumed) begin
      case (det_phase)
        PH_FILL: begin
          win_mem[wr_ptr % DEF_WINDOW] = mag;
          win_sum = win_sum + mag;
          wr_ptr  = (wr_ptr + 1) % DEF_WINDOW;
          det_count++;
          if (det_count >= DEF_WINDOW) begin
            wr_ptr    = 0;
            det_phase = PH_DIP;
            det_count = 0;
            ev        = settle_search();
          end
        end
        PH_DIP: begin
          slide_window(mag);
          if (det_count >= dip_limit) begin
            ev = EV_TIMEOUT;
            if (scan_on) begin
              timeout_tally = timeout_tally + 1'b1;
              if (timeout_tally >= NOSIG_ATTEMPTS) begin
                ev            = EV_NOSIG;
                timeout_tally = '0;
              end
            end
            restart_fill();
          end else begin
            det_count++;
            ev = settle_search();
          end
        end
        PH_END: begin
          slide_window(mag);
          if (det_count >= null_len + DEF_WINDOW) begin
            ev = EV_TIMEOUT;
            restart_fill();
          end else begin
            det_count++;
            ev = settle_search();
          end
        end
        PH_HELD: begin
          if (lost) restart_fill();
        end
        default: restart_fill();
      endcase
    end
    r.event_res  = ev;
    r.phase_code = det_phase;
    r.level_out  = lvl_acc[DEF_LEVEL_SHIFT +: LEVEL_OUT_W];
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      smp_if.valid <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        expected_reports.push_back(detect_step(smp_if.magnitude, smp_if.lost_sync));
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          nxt = sample_queue.pop_front();
          smp_if.valid     <= 1'b1;
          smp_if.magnitude <= nxt.mag;
          smp_if.lost_sync <= nxt.lost;
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatches++;
        end else begin
          exp_r = expected_reports.pop_front();
          if (res_if.event_res !== exp_r.event_res) begin
            $error("event_res: expected %0d, got %0d", exp_r.event_res, res_if.event_res);
            mismatches++;
          end
          if (res_if.phase_code !== exp_r.phase_code) begin
            $error("phase_code: expected %0d, got %0d", exp_r.phase_code, res_if.phase_code);
            mismatches++;
          end
          if (res_if.level_out !== exp_r.level_out) begin
            $error("level_out: expected %0d, got %0d", exp_r.level_out, res_if.level_out);
            mismatches++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("null_symbol_detector regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(int unsigned mag, bit lost);
    sample_t s;
    s.mag  = mag[DEF_MAG_BITS-1:0];
    s.lost = lost;
    sample_queue.push_back(s);
    gen_level = gen_level - (gen_level >> DEF_LEVEL_SHIFT) + 64'(s.mag);
    queued_beats++;
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (sample_queue.size() != 0 || smp_if.valid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    logic [CFG_DATA_W-1:0] d;
    int unsigned           w;
    case (idx)
      CFG_WARMUP: w = $bits(warm_cnt);
      CFG_DIP_TIMEOUT: w = $bits(dip_limit);
      CFG_NULL_LENGTH: w = $bits(null_len);
      default: w = $bits(scan_on);
    endcase
    d = val[CFG_DATA_W-1:0];
    // load junk above the register width now and then
    if (w < CFG_DATA_W && $urandom_range(1, 0) == 1) d = d | CFG_DATA_W'($urandom << w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, d);
  endtask

  task automatic queue_frame();
    int unsigned lvl;
    if ($urandom_range(99, 0) < 15) begin
      repeat ($urandom_range(40, 5)) begin
        push_sample($urandom_range(65535, 0), 1'($urandom_range(1, 0)));
      end
    end else begin
      repeat ($urandom_range(50, 10)) push_sample($urandom_range(65535, 20000), 1'b0);
      repeat ($urandom_range(120, 30)) begin
        lvl = 32'(gen_level >> DEF_LEVEL_SHIFT);
        push_sample($urandom_range(lvl / 2, 0), 1'b0);
      end
      repeat ($urandom_range(12, 1)) push_sample($urandom_range(65535, 20000), 1'b0);
      repeat ($urandom_range(3, 0)) push_sample($urandom_range(65535, 0), 1'b0);
      push_sample($urandom_range(65535, 0), 1'b1);
    end
  endtask

  task automatic run_random(int unsigned beats);
    int unsigned stop_at;
    stop_at = queued_beats + beats;
    while (queued_beats < stop_at) queue_frame();
    wait_quiet();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_WARMUP;
    cfg_data         = '0;
    smp_if.valid     = 1'b0;
    smp_if.magnitude = '0;
    smp_if.lost_sync = 1'b0;
    res_if.ready     = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    queued_beats     = 0;
    gen_level        = '0;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // warm-up under the reset count; lost sync is ignored here
    repeat (4) push_sample(0, 1'b0);
    push_sample(0, 1'b1);
    wait_quiet();
    // drop the count below the beats already taken: next beat starts the fill
    write_reg(CFG_WARMUP, 0);
    // zero level and zero sum: dip and end both hit on the last fill beat
    repeat (DEF_WINDOW) push_sample(0, 1'b0);
    push_sample(32'hFFFF, 1'b0);
    push_sample(0, 1'b1);
    wait_quiet();
    // zero timeout: the window empties on the first search beat, timeout wins
    write_reg(CFG_DIP_TIMEOUT, 0);
    push_sample(32'hFFFF, 1'b0);
    repeat (DEF_WINDOW - 1) push_sample(0, 1'b0);
    push_sample(0, 1'b0);
    wait_quiet();

    write_reg(CFG_WARMUP, 32'hFFFF);
    write_reg(CFG_DIP_TIMEOUT, 1);
    write_reg(CFG_NULL_LENGTH, 1);
    write_reg(CFG_SCAN_ENABLE, 1);
    run_random(PHASE_BEATS);

    src_idle_pct = 81;
    write_reg(CFG_DIP_TIMEOUT, 32'h3FFFF);
    write_reg(CFG_NULL_LENGTH, 32'hFFF);
    write_reg(CFG_SCAN_ENABLE, 0);
    run_random(PHASE_BEATS);

    src_idle_pct  = 0;
    snk_stall_pct = 81;
    write_reg(CFG_DIP_TIMEOUT, $urandom_range(150, 30));
    write_reg(CFG_NULL_LENGTH, $urandom_range(80, 1));
    write_reg(CFG_SCAN_ENABLE, 1);
    run_random(PHASE_BEATS);

    src_idle_pct  = 37;
    snk_stall_pct = 37;
    write_reg(CFG_WARMUP, $urandom_range(65535, 0));
    write_reg(CFG_DIP_TIMEOUT, $urandom_range(300, 1));
    write_reg(CFG_NULL_LENGTH, $urandom_range(200, 1));
    write_reg(CFG_SCAN_ENABLE, $urandom_range(1, 0));
    run_random(PHASE_BEATS);

    if (mismatches == 0) begin
      $display("null_symbol_detector regression: pass");
    end else begin
      $display("null_symbol_detector regression: fail");
    end
    $finish;
  end

endmodule
